// ===== rtl/icrc_pkg.sv =====
// shared types and constants for the intron chain redundancy check
`default_nettype none
package icrc_pkg;
  localparam int MaxExons  = 64;
  localparam int CoordBits = 32;
  localparam int IdxBits   = $clog2(MaxExons);
  localparam int CntBits   = $clog2(MaxExons + 1);

  localparam logic [0:0] RegSameFive = 1'b0;
  localparam logic [0:0] RegPoking   = 1'b1;

  typedef logic [CoordBits-1:0] coord_t;
  typedef logic [IdxBits-1:0] idx_t;
  typedef logic [CntBits-1:0] cnt_t;

  // controller to datapath
  typedef struct packed {
    logic store;
    logic rd_en;
  } icrc_cmd_t;
endpackage
`default_nettype wire

// ===== rtl/icrc_datapath.sv =====
// exon stores and comparison walk
`default_nettype none
module icrc_datapath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire icrc_pkg::icrc_cmd_t cmd,
  input  wire logic              in_second,
  input  wire icrc_pkg::coord_t  in_start,
  input  wire icrc_pkg::coord_t  in_end,
  input  wire logic              in_minus,
  input  wire logic              same_five,
  input  wire logic              poking,
  output logic                   done,
  output logic                   red,
  output logic                   ovf
);
  import icrc_pkg::*;

  // exon stores, one read port each
  coord_t as_mem [MaxExons];
  coord_t ae_mem [MaxExons];
  coord_t bs_mem [MaxExons];
  coord_t be_mem [MaxExons];
  coord_t as_q, ae_q, bs_q, be_q;
  idx_t   ra_s, ra_e, rb_s, rb_e;

  cnt_t acnt, bcnt;
  logic minus, ovf_seen;

  // walk state
  typedef enum logic [3:0] {
    W_IDLE, W_CHK0, W_CHK1, W_SCAN, W_SCAN_E, W_T1, W_T1_E, W_T2, W_T2_E,
    W_M, W_M_E, W_TL, W_TL_E, W_FIN
  } walk_t;
  walk_t  w;
  cnt_t   i, j, i_first, j_first, imax, jmax;
  coord_t r0;
  logic   ok;

  // write ports and registered read ports
  always_ff @(posedge clk) begin
    if (cmd.store && !in_second && acnt < cnt_t'(MaxExons)) begin
      as_mem[acnt[IdxBits-1:0]] <= in_start;
      ae_mem[acnt[IdxBits-1:0]] <= in_end;
    end
    if (cmd.store && in_second && bcnt < cnt_t'(MaxExons)) begin
      bs_mem[bcnt[IdxBits-1:0]] <= in_start;
      be_mem[bcnt[IdxBits-1:0]] <= in_end;
    end
    as_q <= as_mem[ra_s];
    ae_q <= ae_mem[ra_e];
    bs_q <= bs_mem[rb_s];
    be_q <= be_mem[rb_e];
  end

  // read addresses follow the walk
  always_comb begin
    ra_s = imax[IdxBits-1:0];
    ra_e = '0;
    rb_s = jmax[IdxBits-1:0];
    rb_e = '0;
    unique case (w)
      W_SCAN, W_M: begin
        ra_s = i[IdxBits-1:0]; ra_e = idx_t'(i - cnt_t'(1));
        rb_s = j[IdxBits-1:0]; rb_e = idx_t'(j - cnt_t'(1));
      end
      W_T1: begin
        ra_s = '0; rb_s = idx_t'(j - cnt_t'(1));
      end
      W_T2: begin
        rb_s = '0; ra_s = idx_t'(i - cnt_t'(1));
      end
      W_TL: begin
        ra_e = i[IdxBits-1:0]; rb_e = j[IdxBits-1:0];
        rb_s = jmax[IdxBits-1:0]; ra_s = i[IdxBits-1:0];
      end
      default: ;
    endcase
  end

  logic start;
  assign start = cmd.rd_en && w == W_IDLE;

  // counters, flags and the walk sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      acnt <= '0; bcnt <= '0; minus <= 1'b0; ovf_seen <= 1'b0; w <= W_IDLE;
      done <= 1'b0;
    end else begin
      done <= w == W_FIN;
      if (cmd.store) begin
        if (!in_second) begin
          minus <= in_minus;
          if (acnt < cnt_t'(MaxExons)) acnt <= acnt + cnt_t'(1);
          else ovf_seen <= 1'b1;
        end else begin
          if (bcnt < cnt_t'(MaxExons)) bcnt <= bcnt + cnt_t'(1);
          else ovf_seen <= 1'b1;
        end
      end
      unique case (w)
        W_IDLE: if (start) begin
          imax <= acnt - cnt_t'(1); jmax <= bcnt - cnt_t'(1);
          i <= cnt_t'(1); j <= cnt_t'(1);
          ok <= !ovf_seen && acnt >= cnt_t'(2) && bcnt >= cnt_t'(2);
          w <= (!ovf_seen && acnt >= cnt_t'(2) && bcnt >= cnt_t'(2)) ? W_CHK0 : W_FIN;
        end
        W_CHK0: w <= W_CHK1;
        W_CHK1: begin
          if (as_q < be_q || bs_q < ae_q) begin ok <= 1'b0; w <= W_FIN; end
          else w <= W_SCAN;
        end
        W_SCAN: w <= W_SCAN_E;
        W_SCAN_E: begin
          // as_q=ai_hi ae_q=ai_lo bs_q=bj_hi be_q=bj_lo
          if (bs_q < ae_q) begin
            if (j == jmax) begin ok <= 1'b0; w <= W_FIN; end
            else begin j <= j + cnt_t'(1); w <= W_SCAN; end
          end else if (as_q < be_q) begin
            if (i == imax) begin ok <= 1'b0; w <= W_FIN; end
            else begin i <= i + cnt_t'(1); w <= W_SCAN; end
          end else if (ae_q != be_q || as_q != bs_q || (i > cnt_t'(1) && j > cnt_t'(1))) begin
            ok <= 1'b0; w <= W_FIN;
          end else begin
            i_first <= i; j_first <= j; w <= W_T1;
          end
        end
        W_T1: w <= W_T1_E;
        W_T1_E: begin
          // as_q=as[0] bs_q=bs[j-1]
          if (!poking && j > i && as_q < bs_q) begin ok <= 1'b0; w <= W_FIN; end
          else w <= W_T2;
        end
        W_T2: w <= W_T2_E;
        W_T2_E: begin
          // bs_q=bs[0] as_q=as[i-1]
          if (!poking && i > j && bs_q < as_q) begin ok <= 1'b0; w <= W_FIN; end
          else begin i <= i + cnt_t'(1); j <= j + cnt_t'(1); w <= W_M; end
        end
        W_M: begin
          if (i > imax || j > jmax) begin
            i <= i - cnt_t'(1); j <= j - cnt_t'(1); w <= W_TL;
          end else w <= W_M_E;
        end
        W_M_E: begin
          if (ae_q != be_q || as_q != bs_q) begin ok <= 1'b0; w <= W_FIN; end
          else begin i <= i + cnt_t'(1); j <= j + cnt_t'(1); w <= W_M; end
        end
        W_TL: w <= W_TL_E;
        W_TL_E: begin
          // ae_q=ae[i] be_q=be[j] bs_q=bs[jmax] r0=as[imax]
          if ((j_first > i_first && r0 > bs_q) || (i_first > j_first && bs_q > r0)
              || (!poking && i == imax && j < jmax && ae_q > be_q)
              || (!poking && j == jmax && i < imax && be_q > ae_q)
              || (same_five && imax != jmax && !minus && i_first != j_first)
              || (same_five && imax != jmax && minus && (imax - i) != (jmax - j)))
            ok <= 1'b0;
          w <= W_FIN;
        end
        W_FIN: begin
          red <= ok; ovf <= ovf_seen;
          acnt <= '0; bcnt <= '0; minus <= 1'b0; ovf_seen <= 1'b0;
          w <= W_IDLE;
        end
        default: w <= W_IDLE;
      endcase
    end
  end

  // keep as[imax] from the first check for the last-intron containment
  always_ff @(posedge clk) begin
    if (w == W_CHK1) r0 <= as_q;
  end

  property p_done_pulse;
    @(posedge clk) disable iff (rst) done |=> !done;
  endproperty
  a_done_pulse: assert property (p_done_pulse) else $error("done held");
  a_cnt_a: assert property (@(posedge clk) disable iff (rst) acnt <= cnt_t'(MaxExons))
    else $error("first count past store");
  a_cnt_b: assert property (@(posedge clk) disable iff (rst) bcnt <= cnt_t'(MaxExons))
    else $error("second count past store");
endmodule
`default_nettype wire

// ===== rtl/icrc_ctrl.sv =====
// handshake controller
`default_nettype none
module icrc_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_fire,
  input  wire logic               in_last,
  input  wire logic               done,
  input  wire logic               out_fire,
  output logic                    in_ready,
  output logic                    out_valid,
  output icrc_pkg::icrc_cmd_t     cmd
);
  import icrc_pkg::*;

  typedef enum logic [1:0] {S_LOAD, S_JUDGE, S_HOLD} state_t;
  state_t st;

  // loading goes on while a result waits; the judge waits for the result to leave
  assign in_ready = st == S_LOAD;

  always_comb begin
    cmd.store = in_fire;
    cmd.rd_en = st == S_JUDGE && !done && !out_valid;
  end

  // load, then judge; the result is held on out_valid until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_LOAD; out_valid <= 1'b0;
    end else begin
      if (out_fire) out_valid <= 1'b0;
      unique case (st)
        S_LOAD:  if (in_fire && in_last) st <= S_JUDGE;
        S_JUDGE: if (done) begin out_valid <= 1'b1; st <= S_LOAD; end
        default: st <= S_LOAD;
      endcase
    end
  end

  a_no_in_judge: assert property (@(posedge clk) disable iff (rst)
    st == S_JUDGE |-> !in_fire) else $error("item taken while judging");
  a_valid_after: assert property (@(posedge clk) disable iff (rst)
    done |=> out_valid) else $error("result lost");
  a_one_out: assert property (@(posedge clk) disable iff (rst)
    done |-> !out_valid) else $error("result overwritten");
endmodule
`default_nettype wire

// ===== rtl/intron_chain_redundancy_check.sv =====
// top level of the intron chain redundancy check
// result: m_tvalid rises after a last item once the judge finishes; the walk is skipped
//   when a transcript holds under two exons or a store overflowed, and otherwise steps
//   over the intron pairs up to imax and jmax, the exon counts minus one; the judge
//   also waits for the previous result to be taken
// throughput: one exon item per cycle while loading, also while a result waits; the
//   judge walk reads the stores one intron pair at a time through registered ports
// reset: synchronous active-high rst clears counts, flags, configuration registers and handshake
`default_nettype none
module intron_chain_redundancy_check (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,  // exon_start, exon_end
  input  wire logic [1:0]  s_tuser,  // req_type, strand_minus
  input  wire logic        s_tlast,  // last_item
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,  // redundant, overflow, zero fill
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [0:0]  cfg_data
);
  import icrc_pkg::*;

  logic same_five, poking, done, red, ovf, in_fire;
  icrc_cmd_t cmd;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      same_five <= 1'b0; poking <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegSameFive: same_five <= cfg_data[0];
        RegPoking:   poking <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_fire = s_tvalid && s_tready;
  assign m_tdata = {6'b0, ovf, red};

  icrc_ctrl u_ctrl (
    .clk, .rst, .in_fire, .in_last(s_tlast), .done,
    .out_fire(m_tvalid && m_tready), .in_ready(s_tready), .out_valid(m_tvalid), .cmd
  );

  icrc_datapath u_dp (
    .clk, .rst, .cmd, .in_second(s_tuser[0]), .in_start(s_tdata[31:0]),
    .in_end(s_tdata[63:32]), .in_minus(s_tuser[1]), .same_five, .poking,
    .done, .red, .ovf
  );
endmodule
`default_nettype wire
